// ----- src/acs_pkg.sv -----
// Package of the acquisition score scheduler: types, codes, constants and helpers.
package acs_pkg;

  localparam int SIGNALS_DEFAULT = 64;
  localparam int HINT_KINDS = 4;

  localparam logic [2:0] CMD_MASK = 3'd0;
  localparam logic [2:0] CMD_WARM = 3'd1;
  localparam logic [2:0] CMD_OBS = 3'd2;
  localparam logic [2:0] CMD_PICK = 3'd3;
  localparam logic [2:0] CMD_ACQ = 3'd4;
  localparam logic [2:0] CMD_DROP = 3'd5;
  localparam logic [2:0] CMD_CLEAR = 3'd6;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam logic [2:0] STAT_DONE = 3'd0;
  localparam logic [2:0] STAT_PICKED = 3'd1;
  localparam logic [2:0] STAT_NOCAND = 3'd2;
  localparam logic [2:0] STAT_TRACK = 3'd3;
  localparam logic [2:0] STAT_RETRY = 3'd4;
  localparam logic [2:0] STAT_IGNORED = 3'd5;

  localparam logic [2:0] REG_ACQ_THR = 3'd0;
  localparam logic [2:0] REG_RETRY_THR = 3'd1;
  localparam logic [2:0] REG_FULL_LOW = 3'd2;
  localparam logic [2:0] REG_FULL_HIGH = 3'd3;
  localparam logic [2:0] REG_STEP = 3'd4;

  localparam logic [1:0] REASON_UNHEALTHY = 2'd1;
  localparam logic [1:0] REASON_BELOW_MASK = 2'd2;

  localparam logic [7:0] ACQ_THR_RESET = 8'd37;
  localparam logic [7:0] RETRY_THR_RESET = 8'd38;
  localparam logic signed [15:0] FULL_LOW_RESET = -16'sd8000;
  localparam logic [14:0] FULL_HIGH_RESET = 15'd8000;
  localparam logic [14:0] STEP_RESET = 15'd1000;

  localparam logic [15:0] RETRY_BASE = 16'd100;
  localparam logic [15:0] HINT_SCORE = 16'd200;

  typedef enum logic [1:0] {
    MODE_SKIP = 2'd0,
    MODE_ACQ = 2'd1,
    MODE_TRACK = 2'd2,
    MODE_UNHEALTHY = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic acq_m;
    logic trk_m;
    logic nd;
    logic [HINT_KINDS-1:0][15:0] score;
    logic signed [15:0] wlo;
    logic signed [15:0] whi;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{
    mode: MODE_ACQ, acq_m: 1'b0, trk_m: 1'b0, nd: 1'b0, score: '0,
    wlo: FULL_LOW_RESET, whi: $signed({1'b0, FULL_HIGH_RESET})
  };

  typedef enum logic [2:0] {
    ST_IDLE, ST_EX, ST_SUM, ST_DIV, ST_SEL, ST_CLR, ST_FIN
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    if (v < -18'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [17:0] entry_sum(input entry_t e);
    return {2'b00, e.score[0]} + {2'b00, e.score[1]} + {2'b00, e.score[2]}
      + {2'b00, e.score[3]};
  endfunction

  function automatic logic eligible(input entry_t e);
    return !e.nd && (e.mode == MODE_ACQ) && !e.acq_m;
  endfunction

endpackage

// ----- src/acs_mem.sv -----
// Entry table memory with one write port, one registered read port and per-entry valid bits.
module acs_mem import acs_pkg::*; #(
  parameter int SIGNALS = SIGNALS_DEFAULT,
  localparam int AW = $clog2(SIGNALS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [SIGNALS];
  entry_t data_q;
  logic [SIGNALS-1:0] valid;
  logic vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      vld_q <= valid[rd_addr];
    end
  end

  assign rd_data = vld_q ? data_q : RESET_ENTRY;

endmodule

// ----- src/acs_div.sv -----
// Restoring divider that yields a 32-bit dividend modulo a divisor, one bit per cycle.
module acs_div import acs_pkg::*; #(
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] remainder
);

  logic [4:0] cnt;
  logic [31:0] dvd;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [DW:0] rem_sh;
  logic [DW:0] rem_sub;

  always_comb begin
    rem_sh = {rem, dvd[31]};
    rem_sub = (rem_sh >= {1'b0, dsr}) ? rem_sh - {1'b0, dsr} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      rem <= rem_sub[DW-1:0];
    end
  end

  assign remainder = rem;

endmodule

// ----- src/acquisition_score_scheduler.sv -----
// Top level of the acquisition score scheduler: command sequencer around the entry table.
//
// Commands arrive as beats on the input channel (in_valid, in_stall) and each
// one yields exactly one result beat on the output channel (out_valid,
// out_stall). One command is worked on at a time; in_stall is high from the
// accepted beat until its result has been loaded into the output register.
// Commands on a single entry pass through the table read at acceptance,
// a modify and write back, then the output load; the next beat can be
// accepted once the result is loaded. A pick sweeps the table once to sum
// scores, waits for the serial modulo unit, then sweeps again until the
// chosen entry is reached. Clearing unhealthy signals sweeps the table
// once. The sweeps are set by the single read port of the table memory.
// Registers are written through cfg_valid, cfg_index and cfg_data; cfg_ready
// is always high. Reset restores register defaults and marks every table
// entry as holding its reset value, with no clearing pass. A result beat
// held by out_stall stays in the output register and the block waits.
module acquisition_score_scheduler import acs_pkg::*; #(
  parameter int SIGNALS = SIGNALS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic [5:0]         signal_index,
  input  logic [2:0]         mask_bits,
  input  logic [15:0]        score_value,
  input  logic signed [15:0] window_low,
  input  logic signed [15:0] window_high,
  input  logic [31:0]        random_value,
  input  logic [7:0]         carrier_to_noise,
  input  logic signed [15:0] doppler_hz,
  input  logic               channel_free,
  input  logic               long_run,
  input  logic [1:0]         drop_reason,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [5:0]         picked_index,
  output logic signed [15:0] pick_low,
  output logic signed [15:0] pick_high,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW = $clog2(SIGNALS);
  localparam int SUM_W = 18 + AW;

  logic [7:0] acq_thr;
  logic [7:0] retry_thr;
  logic signed [15:0] full_low;
  logic [14:0] full_high;
  logic [14:0] step;

  state_t state, state_next;
  logic [2:0] cmd_q;
  logic [AW-1:0] idx_q;
  logic [2:0] mbits_q;
  logic [15:0] score_q;
  logic signed [15:0] wlo_q, whi_q;
  logic [31:0] rnd_q;
  logic [7:0] cn0_q;
  logic signed [15:0] cf_q;
  logic chf_q, lr_q;
  logic [1:0] reason_q;

  logic [AW:0] issue_cnt, issue_cnt_next;
  logic p_valid, p_valid_next;
  logic [AW-1:0] p_idx, p_idx_next;
  logic [SUM_W-1:0] total, total_next;
  logic [SUM_W-1:0] r, r_next;
  logic [2:0] res_status, res_status_next;
  logic [AW-1:0] res_idx, res_idx_next;
  logic signed [15:0] res_lo, res_lo_next, res_hi, res_hi_next;

  logic [AW-1:0] rd_addr;
  entry_t cur;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;

  logic div_start, div_busy, div_done;
  logic [SUM_W-1:0] div_rem;

  logic accept, issuing, bad_idx, out_load;
  logic [17:0] esum;
  logic signed [16:0] diff17, half17;
  logic signed [17:0] nh18, nl18, fwh18, fwl18, rl18, rh18;

  acs_mem #(.SIGNALS(SIGNALS)) u_mem (
    .clk(clk), .rst(rst), .rd_addr(rd_addr), .rd_data(cur),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  acs_div #(.DW(SUM_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(rnd_q), .divisor(total),
    .busy(div_busy), .done(div_done), .remainder(div_rem)
  );

  assign cfg_ready = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign bad_idx = (32'(signal_index) >= SIGNALS);
  assign issuing = (issue_cnt < (AW+1)'(SIGNALS));
  assign out_load = (state == ST_FIN) && (!out_valid || !out_stall);

  always_comb begin
    esum = entry_sum(cur);
    diff17 = $signed({cur.whi[15], cur.whi}) - $signed({cur.wlo[15], cur.wlo});
    half17 = diff17 >>> 1;
    fwh18 = $signed({3'b000, full_high});
    fwl18 = $signed({{2{full_low[15]}}, full_low});
    nh18 = $signed({{2{cur.whi[15]}}, cur.whi}) + $signed({half17[16], half17});
    nl18 = $signed({{2{cur.wlo[15]}}, cur.wlo}) - $signed({half17[16], half17});
    if (nh18 > fwh18) nh18 = fwh18;
    if (nl18 < fwl18) nl18 = fwl18;
    rl18 = $signed({{2{cf_q[15]}}, cf_q}) - $signed({3'b000, step});
    rh18 = $signed({{2{cf_q[15]}}, cf_q}) + $signed({3'b000, step});
  end

  always_comb begin
    state_next = state;
    issue_cnt_next = issue_cnt;
    p_valid_next = 1'b0;
    p_idx_next = p_idx;
    total_next = total;
    r_next = r;
    res_status_next = res_status;
    res_idx_next = res_idx;
    res_lo_next = res_lo;
    res_hi_next = res_hi;
    rd_addr = idx_q;
    wr_en = 1'b0;
    wr_addr = idx_q;
    wr_data = cur;
    div_start = 1'b0;
    if (state == ST_SUM || state == ST_SEL || state == ST_CLR) begin
      rd_addr = issue_cnt[AW-1:0];
      p_valid_next = issuing;
      p_idx_next = issue_cnt[AW-1:0];
      if (issuing) issue_cnt_next = issue_cnt + 1'b1;
    end
    unique case (state)
      ST_IDLE: begin
        rd_addr = AW'(signal_index);
        res_status_next = STAT_DONE;
        res_idx_next = '0;
        res_lo_next = '0;
        res_hi_next = '0;
        issue_cnt_next = '0;
        total_next = '0;
        if (accept) begin
          if (cmd == CMD_PICK) begin
            state_next = ST_SUM;
          end else if (cmd == CMD_CLEAR) begin
            state_next = ST_CLR;
          end else if (cmd == CMD_UNUSED || bad_idx) begin
            res_status_next = STAT_IGNORED;
            state_next = ST_FIN;
          end else begin
            state_next = ST_EX;
          end
        end
      end
      ST_EX: begin
        wr_en = 1'b1;
        state_next = ST_FIN;
        case (cmd_q)
          CMD_MASK: begin
            wr_data.acq_m = mbits_q[0];
            wr_data.trk_m = mbits_q[1];
            wr_data.nd = mbits_q[2];
          end
          CMD_WARM: begin
            wr_data.score[0] = score_q;
            wr_data.wlo = wlo_q;
            wr_data.whi = whi_q;
          end
          CMD_OBS: wr_data.score[3] = HINT_SCORE;
          CMD_ACQ: begin
            if (cn0_q < acq_thr) begin
              wr_data.whi = sat16(nh18);
              wr_data.wlo = sat16(nl18);
              for (int h = 0; h < HINT_KINDS; h++) begin
                wr_data.score[h] = 16'((({2'b00, cur.score[h]}
                  + {1'b0, cur.score[h], 1'b0}) >> 2));
              end
              wr_data.score[1] = '0;
            end else if (cur.mode == MODE_TRACK) begin
              res_status_next = STAT_IGNORED;
            end else if (!chf_q) begin
              if (cn0_q > retry_thr) begin
                wr_data.score[1] = RETRY_BASE + {8'd0, cn0_q} - {8'd0, acq_thr};
                wr_data.wlo = sat16(rl18);
                wr_data.whi = sat16(rh18);
                res_status_next = STAT_RETRY;
              end else begin
                res_status_next = STAT_IGNORED;
              end
            end else begin
              wr_data.mode = MODE_TRACK;
              res_status_next = STAT_TRACK;
            end
          end
          CMD_DROP: begin
            if (lr_q) begin
              wr_data.score[2] = HINT_SCORE;
              wr_data.wlo = sat16(rl18);
              wr_data.whi = sat16(rh18);
            end
            wr_data.mode = MODE_ACQ;
            if (reason_q == REASON_UNHEALTHY) begin
              wr_data.mode = MODE_UNHEALTHY;
            end else if (reason_q == REASON_BELOW_MASK) begin
              wr_data.score = '0;
            end
          end
          default: wr_en = 1'b0;
        endcase
      end
      ST_SUM: begin
        if (p_valid && eligible(cur)) total_next = total + SUM_W'(esum);
        if (!issuing && !p_valid) begin
          if (total == '0) begin
            res_status_next = STAT_NOCAND;
            state_next = ST_FIN;
          end else begin
            div_start = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        issue_cnt_next = '0;
        if (div_done) begin
          r_next = div_rem;
          state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        if (p_valid && eligible(cur)) begin
          if (r < SUM_W'(esum)) begin
            wr_addr = p_idx;
            res_lo_next = cur.wlo;
            res_hi_next = cur.whi;
            if (cur.wlo > cur.whi) begin
              wr_en = 1'b1;
              wr_data.wlo = full_low;
              wr_data.whi = $signed({1'b0, full_high});
              res_lo_next = full_low;
              res_hi_next = $signed({1'b0, full_high});
            end
            res_status_next = STAT_PICKED;
            res_idx_next = p_idx;
            state_next = ST_FIN;
          end else begin
            r_next = r - SUM_W'(esum);
          end
        end else if (!issuing && !p_valid) begin
          res_status_next = STAT_NOCAND;
          state_next = ST_FIN;
        end
      end
      ST_CLR: begin
        if (p_valid && cur.mode == MODE_UNHEALTHY) begin
          wr_en = 1'b1;
          wr_addr = p_idx;
          wr_data.mode = MODE_ACQ;
        end
        if (!issuing && !p_valid) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      p_valid <= 1'b0;
      issue_cnt <= '0;
      out_valid <= 1'b0;
      acq_thr <= ACQ_THR_RESET;
      retry_thr <= RETRY_THR_RESET;
      full_low <= FULL_LOW_RESET;
      full_high <= FULL_HIGH_RESET;
      step <= STEP_RESET;
    end else begin
      state <= state_next;
      p_valid <= p_valid_next;
      issue_cnt <= issue_cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACQ_THR: acq_thr <= cfg_data[7:0];
          REG_RETRY_THR: retry_thr <= cfg_data[7:0];
          REG_FULL_LOW: full_low <= cfg_data;
          REG_FULL_HIGH: full_high <= cfg_data[14:0];
          REG_STEP: step <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx <= p_idx_next;
    total <= total_next;
    r <= r_next;
    res_status <= res_status_next;
    res_idx <= res_idx_next;
    res_lo <= res_lo_next;
    res_hi <= res_hi_next;
    if (accept) begin
      cmd_q <= cmd;
      idx_q <= AW'(signal_index);
      mbits_q <= mask_bits;
      score_q <= score_value;
      wlo_q <= window_low;
      whi_q <= window_high;
      rnd_q <= random_value;
      cn0_q <= carrier_to_noise;
      cf_q <= doppler_hz;
      chf_q <= channel_free;
      lr_q <= long_run;
      reason_q <= drop_reason;
    end
    if (out_load) begin
      status <= res_status;
      picked_index <= 6'(res_idx);
      pick_low <= res_lo;
      pick_high <= res_hi;
    end
  end

  a_div_in_pick: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == ST_DIV))
    else $error("modulo unit busy outside a pick");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_EX || state == ST_SEL || state == ST_CLR))
    else $error("table written outside an update state");

  a_pick_fields: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && (status != STAT_PICKED) |->
      (picked_index == '0 && pick_low == '0 && pick_high == '0))
    else $error("pick fields set on a result that is not a pick");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    $past(accept) && !$past(rst) |-> in_stall)
    else $error("new beat allowed before the previous command finished");

endmodule
